@@ hdl/rbrp_pkg.sv @@
// Package: types, constants and helpers of the ring buffer resampling player.
`default_nettype none
package rbrp_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int BLOCK_SIZE = 512;
	localparam int FRAC_BITS  = 16;

	localparam int RING_AW   = $clog2(RING_DEPTH);
	localparam int FILL_W    = RING_AW + 1;
	localparam int WCNT_W    = 32;
	localparam int POS_W     = WCNT_W + FRAC_BITS;
	localparam int RATE_W    = 20;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 1;
	localparam int CMD_W     = 3;

	// rate ratio arrives with 16 fraction bits
	localparam int RATE_FRAC = 16;
	localparam int RATE_SHL  = (FRAC_BITS >= RATE_FRAC) ? FRAC_BITS - RATE_FRAC : 0;
	localparam int RATE_SHR  = (FRAC_BITS >= RATE_FRAC) ? 0 : RATE_FRAC - FRAC_BITS;

	localparam logic [POS_W:0] BLOCK_FIX = (POS_W + 1)'(BLOCK_SIZE) << FRAC_BITS;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

	localparam logic [CFG_IDX_W-1:0] REG_LOOPING = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RATE    = CFG_IDX_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 3'd0,
		CMD_PULL  = 3'd1,
		CMD_END   = 3'd2,
		CMD_PLAY  = 3'd3,
		CMD_RESET = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]           command;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic                       play;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       refill_request;
		logic                       is_playing;
	} out_item_t;

	function automatic logic [POS_W-1:0] scale_rate(input logic [RATE_W-1:0] r);
		return POS_W'(r >> RATE_SHR) << RATE_SHL;
	endfunction

endpackage
`default_nettype wire

@@ hdl/rbrp_ring.sv @@
// Sample ring memory: one write port, two registered read ports.
`default_nettype none
module rbrp_ring (
	input  wire logic                                clk,
	input  wire logic                                wr_en,
	input  wire logic [rbrp_pkg::RING_AW-1:0]        wr_addr,
	input  wire logic signed [rbrp_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic                                rd_en,
	input  wire logic [rbrp_pkg::RING_AW-1:0]        rd_addr_a,
	input  wire logic [rbrp_pkg::RING_AW-1:0]        rd_addr_b,
	output logic signed [rbrp_pkg::SAMPLE_W-1:0]      rd_data_a,
	output logic signed [rbrp_pkg::SAMPLE_W-1:0]      rd_data_b
);

	logic signed [rbrp_pkg::SAMPLE_W-1:0] mem [rbrp_pkg::RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

@@ hdl/rbrp_interp.sv @@
// Linear interpolation between two samples, round half up, saturated.
`default_nettype none
module rbrp_interp (
	input  wire logic signed [rbrp_pkg::SAMPLE_W-1:0] start_val,
	input  wire logic signed [rbrp_pkg::SAMPLE_W-1:0] end_val,
	input  wire logic [rbrp_pkg::FRAC_BITS-1:0]       frac,
	output logic signed [rbrp_pkg::SAMPLE_W-1:0]      result
);

	localparam int DIFF_W = rbrp_pkg::SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + rbrp_pkg::FRAC_BITS + 2;
	localparam int STEP_W = PROD_W - rbrp_pkg::FRAC_BITS;
	localparam int SUM_W  = STEP_W + 1;
	localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'(2 ** (rbrp_pkg::SAMPLE_W - 1) - 1);
	localparam logic signed [SUM_W-1:0] MIN_V = -SUM_W'(2 ** (rbrp_pkg::SAMPLE_W - 1));
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (rbrp_pkg::FRAC_BITS - 1);

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rounded;
	logic signed [STEP_W-1:0] step;
	logic signed [SUM_W-1:0]  sum;

	always_comb begin
		diff    = DIFF_W'(end_val) - DIFF_W'(start_val);
		prod    = PROD_W'(diff) * $signed({2'b00, frac});
		rounded = prod + HALF;
		// arithmetic shift gives the floor of the rounded quotient
		step    = STEP_W'(rounded >>> rbrp_pkg::FRAC_BITS);
		sum     = SUM_W'(start_val) + SUM_W'(step);
		if (sum > MAX_V) begin
			result = MAX_V[rbrp_pkg::SAMPLE_W-1:0];
		end else if (sum < MIN_V) begin
			result = MIN_V[rbrp_pkg::SAMPLE_W-1:0];
		end else begin
			result = sum[rbrp_pkg::SAMPLE_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ hdl/ring_buffer_resampling_player_top.sv @@
// Top level of the ring buffer resampling player.
`default_nettype none
// Resampling sample player. Each input transaction carries a command: push
// writes one Q1.15 sample into a 4096-entry ring at the write count, pull
// produces one output transaction, end of source stops playback unless
// looping is set, set playing loads the playing flag, and reset positions
// clears write count and read position (ring contents are kept). A pull while
// playing with the read position behind the write count returns the linear
// interpolation between the two ring entries around the read position and
// advances it by rate_ratio (unsigned Q4.16); otherwise it returns zero.
// While playing, refill_request flags that under one block of samples lies ahead.
// Throughput is one input transaction per clock while the output is not
// stalled with stage 1 full; a pull result goes through the registered ring
// read (addresses issued at acceptance), then the interpolation multiply into
// the output register. Ring entries never written since reset read as zero,
// tracked by a fill count, so no clearing pass is needed after reset.
// Configuration writes (index 0 looping, index 1 rate_ratio) take effect at
// once and are meant to be issued while no pull is in flight.
module ring_buffer_resampling_player_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [rbrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rbrp_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire rbrp_pkg::in_item_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output rbrp_pkg::out_item_t                     out_data
);

	localparam int AW = rbrp_pkg::RING_AW;
	localparam int FB = rbrp_pkg::FRAC_BITS;

	// configuration registers
	logic                        looping_q;
	logic [rbrp_pkg::RATE_W-1:0] rate_q;

	// player state
	logic [rbrp_pkg::WCNT_W-1:0] wcnt_q;
	logic [rbrp_pkg::POS_W-1:0]  rpos_q;
	logic                        playing_q;
	logic [rbrp_pkg::FILL_W-1:0] fill_q;

	// stage 1: ring read in flight
	logic                        valid_s1;
	logic                        active_s1;
	logic                        playing_s1;
	logic                        va_s1;
	logic                        vb_s1;
	logic [FB-1:0]               frac_s1;
	logic [rbrp_pkg::POS_W-1:0]  rpos_s1;
	logic [rbrp_pkg::WCNT_W-1:0] wcnt_s1;

	logic                        in_fire;
	logic                        advance;
	logic                        pull_fire;
	logic                        push_fire;
	rbrp_pkg::cmd_t              cmd;
	logic [rbrp_pkg::POS_W-1:0]  wpos;
	logic                        ahead;
	logic [rbrp_pkg::WCNT_W-1:0] ipos;
	logic [AW-1:0]               idx_a;
	logic [AW-1:0]               idx_b;
	logic [rbrp_pkg::POS_W-1:0]  rpos_next;
	logic                        wcnt_in_ring;
	logic [rbrp_pkg::FILL_W-1:0] wcnt_low;

	logic signed [rbrp_pkg::SAMPLE_W-1:0] rd_a;
	logic signed [rbrp_pkg::SAMPLE_W-1:0] rd_b;
	logic signed [rbrp_pkg::SAMPLE_W-1:0] start_val;
	logic signed [rbrp_pkg::SAMPLE_W-1:0] end_val;
	logic signed [rbrp_pkg::SAMPLE_W-1:0] interp_val;
	logic [rbrp_pkg::POS_W:0]             ahead_pos;
	logic                                 refill;
	rbrp_pkg::out_item_t                  result;

	// handshake: output register drains, stage 1 moves into it
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	always_comb begin
		cmd       = rbrp_pkg::cmd_t'(in_data.command);
		push_fire = 1'b0;
		pull_fire = 1'b0;
		unique case (cmd)
			rbrp_pkg::CMD_PUSH: push_fire = in_fire;
			rbrp_pkg::CMD_PULL: pull_fire = in_fire;
			default: ;
		endcase
	end

	// position math for the current transaction
	always_comb begin
		wpos         = {wcnt_q, FB'(0)};
		ahead        = playing_q && (rpos_q < wpos);
		ipos         = rpos_q[rbrp_pkg::POS_W-1:FB];
		idx_a        = ipos[AW-1:0];
		idx_b        = idx_a + AW'(1);
		rpos_next    = ahead ? rpos_q + rbrp_pkg::scale_rate(rate_q) : rpos_q;
		wcnt_in_ring = (wcnt_q[rbrp_pkg::WCNT_W-1:AW] == '0);
		wcnt_low     = {1'b0, wcnt_q[AW-1:0]};
	end

	rbrp_ring u_ring (
		.clk       (clk),
		.wr_en     (push_fire),
		.wr_addr   (wcnt_q[AW-1:0]),
		.wr_data   (in_data.sample_value),
		.rd_en     (pull_fire),
		.rd_addr_a (idx_a),
		.rd_addr_b (idx_b),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			looping_q <= 1'b0;
			rate_q    <= rbrp_pkg::RATE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rbrp_pkg::REG_LOOPING: looping_q <= cfg_data[0];
				rbrp_pkg::REG_RATE:    rate_q    <= cfg_data[rbrp_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// command execution: state moves at acceptance so the next transaction sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q    <= '0;
			rpos_q    <= '0;
			playing_q <= 1'b0;
			fill_q    <= '0;
		end else if (in_fire) begin
			unique case (cmd)
				rbrp_pkg::CMD_PUSH: begin
					wcnt_q <= wcnt_q + rbrp_pkg::WCNT_W'(1);
					// entries below the fill count have been written at least once
					if (wcnt_in_ring && (wcnt_low >= fill_q)) begin
						fill_q <= wcnt_low + rbrp_pkg::FILL_W'(1);
					end
				end
				rbrp_pkg::CMD_PULL: rpos_q <= rpos_next;
				rbrp_pkg::CMD_END: begin
					if (!looping_q) begin
						playing_q <= 1'b0;
					end
				end
				rbrp_pkg::CMD_PLAY: playing_q <= in_data.play;
				rbrp_pkg::CMD_RESET: begin
					wcnt_q <= '0;
					rpos_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pull_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, loaded together with the ring read
	always_ff @(posedge clk) begin
		if (pull_fire) begin
			active_s1  <= ahead;
			playing_s1 <= playing_q;
			va_s1      <= {1'b0, idx_a} < fill_q;
			vb_s1      <= {1'b0, idx_b} < fill_q;
			frac_s1    <= rpos_q[FB-1:0];
			rpos_s1    <= rpos_next;
			wcnt_s1    <= wcnt_q;
		end
	end

	// unwritten entries read as zero
	assign start_val = va_s1 ? rd_a : '0;
	assign end_val   = vb_s1 ? rd_b : '0;

	rbrp_interp u_interp (
		.start_val (start_val),
		.end_val   (end_val),
		.frac      (frac_s1),
		.result    (interp_val)
	);

	always_comb begin
		ahead_pos             = {1'b0, rpos_s1} + rbrp_pkg::BLOCK_FIX;
		refill                = playing_s1 && (ahead_pos > {1'b0, wcnt_s1, FB'(0)});
		result.sample_out     = active_s1 ? interp_val : '0;
		result.refill_request = refill;
		result.is_playing     = playing_s1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data <= result;
		end
	end

`ifndef SYNTH
	a_idle_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_playing |->
			out_data.sample_out == '0 && !out_data.refill_request)
		else $error("output not silent while not playing");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= rbrp_pkg::FILL_W'(rbrp_pkg::RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && out_stall |=> valid_s1 && $stable(rpos_s1))
		else $error("stage 1 lost while output stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_ring_buffer_resampling_player_top.sv @@
// Self-checking testbench for the ring buffer resampling player top level.
`timescale 1ns / 1ps

module tb_ring_buffer_resampling_player_top;
	import rbrp_pkg::*;

	// Receiver and sender wait at most this many cycles per transaction, long hold apart.
	localparam int MAX_WAIT     = 4;
	// One long receiver hold-off, long enough to back the pipeline up.
	localparam int LONG_HOLD    = 250;
	// Extra cycles after the last expected result before touching registers.
	localparam int SETTLE       = 8;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_REPORTS  = 40;
	localparam int CMD_MAX      = (1 << CMD_W) - 1;
	localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;

	// Stimulus waiting for the driver, and results the player must still produce.
	in_item_t  cmd_queue[$];
	out_item_t expected_samples[$];

	// Mirror of the player state and its registers.
	logic signed [SAMPLE_W-1:0] ring_m [RING_DEPTH];
	logic [WCNT_W-1:0]          wr_count_m = '0;
	logic [POS_W-1:0]           rd_pos_m   = '0;
	logic                       playing_m  = 1'b0;
	logic                       looping_m  = 1'b0;
	logic [RATE_W-1:0]          rate_m     = RATE_RESET;

	int          errors       = 0;
	int          results_seen = 0;
	int unsigned gap_left     = 0;
	int unsigned stall_left   = 0;
	int unsigned cycle_count  = 0;
	bit          tx_steady    = 1'b0;
	bit          rx_steady    = 1'b0;

	ring_buffer_resampling_player_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ring_buffer_resampling_player_top verification failed");
			$finish;
		end
	end

	// Advance the mirrored player by one accepted transaction. A pull queues
	// the sample it must produce; every other command only moves state.
	task automatic predict_player(input in_item_t it);
		logic [POS_W-1:0]  wpos;
		logic [WCNT_W-1:0] ip;
		longint            a, b, frac, stepv, v;
		out_item_t         res;
		case (it.command)
		CMD_PUSH: begin
			ring_m[wr_count_m[RING_AW-1:0]] = it.sample_value;
			wr_count_m = wr_count_m + 1'b1;
		end
		CMD_END: begin
			if (!looping_m)
				playing_m = 1'b0;
		end
		CMD_PLAY: begin
			playing_m = it.play;
		end
		CMD_RESET: begin
			wr_count_m = '0;
			rd_pos_m   = '0;
		end
		CMD_PULL: begin
			res = '0;
			if (playing_m) begin
				wpos = {wr_count_m, {FRAC_BITS{1'b0}}};
				if (rd_pos_m < wpos) begin
					ip   = rd_pos_m[POS_W-1:FRAC_BITS];
					frac = rd_pos_m[FRAC_BITS-1:0];
					a    = ring_m[ip[RING_AW-1:0]];
					// neighbor index wraps at 32 bits first, then at the ring depth
					b    = ring_m[RING_AW'(ip + 1'b1)];
					// round half toward plus infinity: floor of (diff * frac + half)
					stepv = ((b - a) * frac + HALF_LSB) >>> FRAC_BITS;
					v     = a + stepv;
					if (v > 32767)
						v = 32767;
					if (v < -32768)
						v = -32768;
					res.sample_out = v[SAMPLE_W-1:0];
					// rescale the Q4.16 ratio to the position's fraction width
					if (FRAC_BITS >= RATE_FRAC)
						rd_pos_m = rd_pos_m + (POS_W'(rate_m) << (FRAC_BITS - RATE_FRAC));
					else
						rd_pos_m = rd_pos_m + (POS_W'(rate_m) >> (RATE_FRAC - FRAC_BITS));
				end
				// plain unsigned compare, one bit wider so the sum cannot wrap
				res.refill_request = ({1'b0, rd_pos_m} + BLOCK_FIX) > {1'b0, wpos};
			end
			res.is_playing = playing_m;
			expected_samples.push_back(res);
		end
		default: begin
			// unused command codes leave everything untouched
		end
		endcase
	endtask

	function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd,
	                                       input logic signed [SAMPLE_W-1:0] smp,
	                                       input logic pl);
		in_item_t it;
		it.command      = cmd;
		it.sample_value = smp;
		it.play         = pl;
		return it;
	endfunction

	// Full-scale values show up often enough to stress the interpolation.
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
		0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
		1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
		2:       return '0;
		default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// Mostly pushes and pulls with random content; end of source, play
	// changes, position resets and unused codes stir the state now and then.
	function automatic in_item_t rand_item(input int pull_pct);
		logic [CMD_W-1:0] cmd;
		int               pick;
		if ($urandom_range(0, 99) < pull_pct) begin
			cmd = CMD_PULL;
		end else begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				cmd = CMD_PUSH;
			else if (pick == 14)
				cmd = CMD_END;
			else if (pick < 17)
				cmd = CMD_PLAY;
			else if (pick == 17)
				cmd = CMD_RESET;
			else
				cmd = CMD_W'($urandom_range(CMD_RESET + 1, CMD_MAX));
		end
		// play mostly stays on so pulls keep producing real samples
		return make_item(cmd, rand_sample(), $urandom_range(0, 3) != 0);
	endfunction

	task automatic note_mismatch(input string what, input int want_v, input int got_v);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
			         $time, what, want_v, got_v);
	endtask

	// Block until every transaction is taken and every result is back, then
	// give the pipeline time to finish anything that produced no result.
	// Look at the falling edge, once the clocked processes have settled.
	task automatic wait_idle();
		while (cmd_queue.size() != 0 || in_valid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == REG_LOOPING)
			looping_m = data[0];
		else
			rate_m = data[RATE_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Drain, reprogram both registers, then start playback, prefill the ring
	// and queue the random mix for this setting.
	task automatic run_phase(input logic loop_v, input logic [RATE_W-1:0] rate_v,
	                         input int n_rand, input int pull_pct, input int prefill);
		wait_idle();
		write_reg(REG_LOOPING, CFG_W'(loop_v));
		write_reg(REG_RATE, CFG_W'(rate_v));
		cmd_queue.push_back(make_item(CMD_PLAY, rand_sample(), 1'b1));
		repeat (prefill)
			cmd_queue.push_back(make_item(CMD_PUSH, rand_sample(), 1'($urandom())));
		repeat (n_rand)
			cmd_queue.push_back(rand_item(pull_pct));
	endtask

	// Input side: hold a stalled transaction, predict each accepted one, then
	// idle for a drawn number of cycles before offering the next. Now and then
	// flip into a steady mode that offers back to back.
	always @(posedge clk) begin : item_driver
		int unsigned gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!(in_valid && in_stall)) begin
			gap = gap_left;
			if (in_valid) begin
				predict_player(in_data);
				gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 31) == 0)
					tx_steady = !tx_steady;
			end
			if (gap != 0 || cmd_queue.size() == 0) begin
				in_valid <= 1'b0;
				gap_left <= (gap != 0) ? gap - 1 : 0;
			end else begin
				in_data  <= cmd_queue.pop_front();
				in_valid <= 1'b1;
			end
		end
	end

	// Output side: check each accepted result against the oldest expectation,
	// then stall for a drawn number of cycles. Twice in the run, hold off for
	// a long stretch so the player fills up and pushes back on its input.
	always @(posedge clk) begin : result_monitor
		int unsigned hold_cycles;
		out_item_t   want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			hold_cycles = stall_left;
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_samples.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t ns: unexpected result, expected none, actual %h",
						         $time, out_data);
				end else begin
					want = expected_samples.pop_front();
					if (out_data.sample_out !== want.sample_out)
						note_mismatch("sample_out", want.sample_out, out_data.sample_out);
					if (out_data.refill_request !== want.refill_request)
						note_mismatch("refill_request", want.refill_request,
						              out_data.refill_request);
					if (out_data.is_playing !== want.is_playing)
						note_mismatch("is_playing", want.is_playing, out_data.is_playing);
				end
				hold_cycles = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
				if (results_seen == 40 || results_seen == 300)
					hold_cycles = LONG_HOLD;
				if ($urandom_range(0, 31) == 0)
					rx_steady = !rx_steady;
			end
			out_stall  <= (hold_cycles != 0);
			stall_left <= (hold_cycles != 0) ? hold_cycles - 1 : 0;
		end
	end

	initial begin
		foreach (ring_m[i])
			ring_m[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings: looping off, unit rate.
		// Pull while stopped, then unused codes that must be ignored.
		cmd_queue.push_back(make_item(CMD_PULL, '0, 1'b0));
		cmd_queue.push_back(make_item(CMD_W'(CMD_RESET + 1), '1, 1'b1));
		cmd_queue.push_back(make_item(CMD_W'(CMD_MAX), '1, 1'b1));
		// Push the sample extremes and small values around zero.
		cmd_queue.push_back(make_item(CMD_PUSH, 16'sh7FFF, 1'b0));
		cmd_queue.push_back(make_item(CMD_PUSH, -16'sh8000, 1'b1));
		cmd_queue.push_back(make_item(CMD_PUSH, 16'sh0000, 1'b0));
		cmd_queue.push_back(make_item(CMD_PUSH, -16'sh0001, 1'b0));
		cmd_queue.push_back(make_item(CMD_PUSH, 16'sh0001, 1'b0));
		cmd_queue.push_back(make_item(CMD_PULL, '0, 1'b0));
		cmd_queue.push_back(make_item(CMD_PLAY, '0, 1'b0));
		cmd_queue.push_back(make_item(CMD_PLAY, '0, 1'b1));
		repeat (3) cmd_queue.push_back(make_item(CMD_PULL, '0, 1'b0));
		// End of source without looping stops playback.
		cmd_queue.push_back(make_item(CMD_END, '0, 1'b0));
		cmd_queue.push_back(make_item(CMD_PULL, '0, 1'b0));
		cmd_queue.push_back(make_item(CMD_PLAY, '0, 1'b1));
		// Read up to the write count; the last pull is starved.
		repeat (3) cmd_queue.push_back(make_item(CMD_PULL, '0, 1'b0));
		// Reset positions while playing; old ring contents stay visible.
		cmd_queue.push_back(make_item(CMD_RESET, '0, 1'b0));
		cmd_queue.push_back(make_item(CMD_PUSH, 16'sd100, 1'b0));
		cmd_queue.push_back(make_item(CMD_PULL, '0, 1'b0));
		cmd_queue.push_back(make_item(CMD_W'(CMD_RESET + 2), 16'sh5A5A, 1'b0));
		cmd_queue.push_back(make_item(CMD_PULL, '0, 1'b0));

		// Random part, one register setting per phase. Half rate exercises
		// the rounding, zero rate freezes the position, the top rate runs
		// past the write count so most of its pulls come back starved.
		run_phase(1'b1, 20'h08000, 150, 45, 16);
		run_phase(1'b0, 20'h00000, 100, 45, 16);
		run_phase(1'b1, 20'hFFFFF, 200, 90, 64);
		run_phase(1'b0, RATE_W'($urandom_range(1, 20'h3FFFF)), 150, 45, 16);
		run_phase(1'b1, 20'h00001, 100, 50, 16);
		run_phase(1'b0, RATE_RESET, 50, 45, 16);

		wait_idle();
		if (expected_samples.size() != 0)
			errors++;
		if (errors == 0)
			$display("ring_buffer_resampling_player_top verification clean");
		else
			$display("ring_buffer_resampling_player_top verification failed");
		$finish;
	end

endmodule
